// File: sv/drp_pkg.sv
// Shared types and constants for the DHCP reply option parser.
// Depends on nothing; used by drp_parse and dhcp_reply_option_parser_top.
package drp_pkg;

    // Fixed layout of a BOOTP/DHCP reply.
    localparam int unsigned HDR_BYTES   = 236;
    localparam logic [9:0]  OFFSET_MAX  = 10'd1023;
    localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;

    // Field codes seen on the wire.
    localparam logic [7:0] OP_REPLY      = 8'd2;
    localparam logic [7:0] OPT_PAD       = 8'd0;
    localparam logic [7:0] OPT_END       = 8'd255;
    localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
    localparam logic [7:0] OPT_SERVER_ID = 8'd54;
    localparam logic [7:0] MSG_OFFER     = 8'd2;
    localparam logic [7:0] MSG_ACK       = 8'd5;
    localparam logic [7:0] MSG_NAK       = 8'd6;

    // Phase of the type-length-value walk.
    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_LEN  = 2'd1,
        PH_SKIP = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    // Verdict reported for each packet.
    typedef enum logic [2:0] {
        VD_NOT_REPLY   = 3'd0,
        VD_WRONG_XID   = 3'd1,
        VD_NO_TYPE     = 3'd2,
        VD_OTHER_TYPE  = 3'd3,
        VD_OFFER       = 3'd4,
        VD_ACK_TAKEN   = 3'd5,
        VD_ACK_IGNORED = 3'd6,
        VD_NAK         = 3'd7
    } verdict_t;

    // One result beat, packed from the highest field down.
    typedef struct packed {
        logic [31:0] host_address;
        logic        address_offered;
        logic        address_allocated;
        logic        server_id_seen;
        logic [31:0] server_address;
        logic [31:0] offered_address;
        logic [7:0]  dhcp_type;
        verdict_t    verdict;
    } result_t;

endpackage

// File: sv/dhcp_reply_option_parser_top.sv
// Top level of the DHCP reply option parser: stream ports, input and result registers.
// Depends on drp_pkg and drp_parse.
//
// The block takes one reply byte per cycle on the s_ side and gives one result
// beat on the m_ side for every byte marked with s_tlast. Each byte passes an
// input register, then combinational parsing logic that updates the header
// captures, the option walk and the client flags; a last byte's result is then
// written to the result register. The per-byte state update of the option walk
// sets the rate: a byte every cycle, sustained, while the result register drains.
// A last byte waits in the input register only while an earlier result is still
// held. The user must write the transaction id through cfg_ only while the block
// is idle; the block itself does not enforce this.
module dhcp_reply_option_parser_top #(
    parameter int OPTION_AREA_BYTES = 312
) (
    input  logic         clk,
    input  logic         rst_n,
    // Configuration write: transaction id.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    // Reply bytes.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] pkt_byte
    input  logic         s_tlast,   // last_byte
    // Results.
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] verdict, [10:3] dhcp_type, [42:11] offered_address,
    // [74:43] server_address, [75] server_id_seen, [76] address_allocated,
    // [77] address_offered, [109:78] host_address, [111:110] zero
    output logic [111:0] m_tdata
);
    import drp_pkg::*;

    logic [31:0] tid_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    result_t     out_data_reg;
    result_t     res;
    logic        out_free;
    logic        advance;

    // A byte moves on unless it is a last byte and the result slot is full.
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tid_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tid_reg <= cfg_data;
        end
    end

    // Input stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    drp_parse #(
        .OPTION_AREA_BYTES(OPTION_AREA_BYTES)
    ) u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .byte_in        (in_byte_reg),
        .last_in        (in_last_reg),
        .transaction_id (tid_reg),
        .result         (res)
    );

    // Result stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

`ifndef NO_ASSERTIONS
    // A result beat only appears after a last byte went through the parser.
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && in_last_reg))
        else $error("result beat without a last byte");

    // A taken ack leaves the client holding an address.
    a_ack_sets_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.verdict == VD_ACK_TAKEN) |->
        out_data_reg.address_allocated)
        else $error("ack taken without allocated flag");

    // A nak clears both client flags.
    a_nak_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.verdict == VD_NAK) |->
        (!out_data_reg.address_allocated && !out_data_reg.address_offered))
        else $error("nak left a client flag set");

    // An offer marks the address as offered.
    a_offer_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.verdict == VD_OFFER) |->
        out_data_reg.address_offered)
        else $error("offer without offered flag");
`endif

endmodule

// File: sv/drp_parse.sv
// Per-byte reply parser: header capture, option walk and client flag update.
// Depends on drp_pkg for codes, the phase enum and the result struct.
module drp_parse #(
    parameter int OPTION_AREA_BYTES = 312
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       byte_in,
    input  logic             last_in,
    input  logic [31:0]      transaction_id,
    output drp_pkg::result_t result
);
    import drp_pkg::*;

    localparam int unsigned AreaEnd = HDR_BYTES + OPTION_AREA_BYTES;
    localparam logic [10:0] AREA_END = 11'(AreaEnd);
    localparam logic [10:0] HDR_END  = 11'(HDR_BYTES);
    localparam logic [10:0] OPT_START = 11'(HDR_BYTES + 4);

    // Per-packet state.
    logic [9:0]  offset_reg, offset_next;
    logic        op_reply_reg, op_reply_next;
    logic [31:0] xid_reg, xid_next;
    logic [31:0] yiaddr_reg, yiaddr_next;
    logic [31:0] cookie_reg, cookie_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  skip_reg, skip_next;
    logic [7:0]  type_val_reg, type_val_next;
    logic        type_found_reg, type_found_next;
    logic [1:0]  type_stage_reg, type_stage_next;
    logic [31:0] srv_val_reg, srv_val_next;
    logic        srv_found_reg, srv_found_next;
    logic [2:0]  srv_stage_reg, srv_stage_next;

    // State kept across packets.
    logic [31:0] server_ip_reg, server_ip_next;
    logic [31:0] host_ip_reg, host_ip_next;
    logic        alloc_reg, alloc_next;
    logic        offered_reg, offered_next;

    // Next state for one byte, and the verdict when the byte is the last one.
    always_comb
    begin
        logic [10:0] off_w;
        logic [10:0] cnt_w;
        logic        cookie_ok;
        logic        xid_ok;
        logic        have_type;
        logic        have_srv;
        logic [7:0]  mt;

        offset_next     = offset_reg;
        op_reply_next   = op_reply_reg;
        xid_next        = xid_reg;
        yiaddr_next     = yiaddr_reg;
        cookie_next     = cookie_reg;
        phase_next      = phase_reg;
        skip_next       = skip_reg;
        type_val_next   = type_val_reg;
        type_found_next = type_found_reg;
        type_stage_next = type_stage_reg;
        srv_val_next    = srv_val_reg;
        srv_found_next  = srv_found_reg;
        srv_stage_next  = srv_stage_reg;
        server_ip_next  = server_ip_reg;
        host_ip_next    = host_ip_reg;
        alloc_next      = alloc_reg;
        offered_next    = offered_reg;
        off_w           = {1'b0, offset_reg};

        if (offset_reg != OFFSET_MAX)
        begin
            if (offset_reg == 10'd0)
            begin
                op_reply_next = (byte_in == OP_REPLY);
            end
            else if (offset_reg >= 10'd4 && offset_reg <= 10'd7)
            begin
                xid_next[8*(3 - offset_reg[1:0]) +: 8] = byte_in;
            end
            else if (offset_reg >= 10'd16 && offset_reg <= 10'd19)
            begin
                yiaddr_next[8*(3 - offset_reg[1:0]) +: 8] = byte_in;
            end
            else if (off_w >= HDR_END && off_w < OPT_START)
            begin
                cookie_next[8*(3 - offset_reg[1:0]) +: 8] = byte_in;
            end
            else if (off_w >= OPT_START && off_w < AREA_END)
            begin
                // Captures already under way take this byte first.
                if (type_stage_reg == 2'd1)
                begin
                    type_stage_next = 2'd2;
                end
                else if (type_stage_reg == 2'd2)
                begin
                    type_val_next   = byte_in;
                    type_found_next = 1'b1;
                    type_stage_next = 2'd0;
                end
                if (srv_stage_reg == 3'd1)
                begin
                    srv_stage_next = 3'd2;
                end
                else if (srv_stage_reg >= 3'd2)
                begin
                    srv_val_next   = {srv_val_reg[23:0], byte_in};
                    srv_stage_next = srv_stage_reg + 3'd1;
                    if (srv_stage_reg == 3'd5)
                    begin
                        srv_found_next = 1'b1;
                        srv_stage_next = 3'd0;
                    end
                end

                // Type-length-value walk.
                case (phase_reg)
                    PH_TYPE:
                    begin
                        if (byte_in == OPT_END)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (byte_in != OPT_PAD)
                        begin
                            if (byte_in == OPT_MSG_TYPE && !type_found_next &&
                                type_stage_next == 2'd0)
                            begin
                                type_stage_next = 2'd1;
                            end
                            if (byte_in == OPT_SERVER_ID && !srv_found_next &&
                                srv_stage_next == 3'd0)
                            begin
                                srv_stage_next = 3'd1;
                            end
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        if (byte_in == 8'd0)
                        begin
                            phase_next = PH_TYPE;
                        end
                        else
                        begin
                            skip_next  = byte_in;
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        if (skip_reg != 8'd0)
                        begin
                            skip_next = skip_reg - 8'd1;
                        end
                        if (skip_next == 8'd0)
                        begin
                            phase_next = PH_TYPE;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            offset_next = offset_reg + 10'd1;
        end

        // Packet verdict, computed from the state after this byte.
        cnt_w     = {1'b0, offset_next};
        cookie_ok = (cnt_w >= OPT_START) && (cookie_next == MAGIC_COOKIE);
        xid_ok    = (offset_next >= 10'd8) && (xid_next == transaction_id);
        have_type = cookie_ok && type_found_next;
        have_srv  = cookie_ok && srv_found_next;
        mt        = have_type ? type_val_next : 8'd0;

        result.verdict = VD_OTHER_TYPE;
        if (last_in)
        begin
            if (!op_reply_next)
            begin
                result.verdict = VD_NOT_REPLY;
            end
            else if (!xid_ok)
            begin
                result.verdict = VD_WRONG_XID;
            end
            else if (!have_type)
            begin
                result.verdict = VD_NO_TYPE;
            end
            else if (mt == MSG_OFFER)
            begin
                result.verdict = VD_OFFER;
                offered_next   = 1'b1;
                if (have_srv)
                begin
                    server_ip_next = srv_val_next;
                end
            end
            else if (mt == MSG_ACK)
            begin
                if (alloc_reg)
                begin
                    result.verdict = VD_ACK_IGNORED;
                end
                else
                begin
                    result.verdict = VD_ACK_TAKEN;
                    host_ip_next   = yiaddr_next;
                    alloc_next     = 1'b1;
                end
            end
            else if (mt == MSG_NAK)
            begin
                result.verdict = VD_NAK;
                alloc_next     = 1'b0;
                offered_next   = 1'b0;
            end
        end

        result.dhcp_type         = mt;
        result.offered_address   = yiaddr_next;
        result.server_address    = server_ip_next;
        result.server_id_seen    = have_srv;
        result.address_allocated = alloc_next;
        result.address_offered   = offered_next;
        result.host_address      = host_ip_next;

        // The last byte starts the next packet from a clean slate.
        if (last_in)
        begin
            offset_next     = 10'd0;
            op_reply_next   = 1'b0;
            xid_next        = 32'd0;
            yiaddr_next     = 32'd0;
            cookie_next     = 32'd0;
            phase_next      = PH_TYPE;
            skip_next       = 8'd0;
            type_val_next   = 8'd0;
            type_found_next = 1'b0;
            type_stage_next = 2'd0;
            srv_val_next    = 32'd0;
            srv_found_next  = 1'b0;
            srv_stage_next  = 3'd0;
        end
    end

    // State registers advance once per processed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            op_reply_reg   <= 1'b0;
            xid_reg        <= '0;
            yiaddr_reg     <= '0;
            cookie_reg     <= '0;
            phase_reg      <= PH_TYPE;
            skip_reg       <= '0;
            type_val_reg   <= '0;
            type_found_reg <= 1'b0;
            type_stage_reg <= '0;
            srv_val_reg    <= '0;
            srv_found_reg  <= 1'b0;
            srv_stage_reg  <= '0;
            server_ip_reg  <= '0;
            host_ip_reg    <= '0;
            alloc_reg      <= 1'b0;
            offered_reg    <= 1'b0;
        end
        else if (step)
        begin
            offset_reg     <= offset_next;
            op_reply_reg   <= op_reply_next;
            xid_reg        <= xid_next;
            yiaddr_reg     <= yiaddr_next;
            cookie_reg     <= cookie_next;
            phase_reg      <= phase_next;
            skip_reg       <= skip_next;
            type_val_reg   <= type_val_next;
            type_found_reg <= type_found_next;
            type_stage_reg <= type_stage_next;
            srv_val_reg    <= srv_val_next;
            srv_found_reg  <= srv_found_next;
            srv_stage_reg  <= srv_stage_next;
            server_ip_reg  <= server_ip_next;
            host_ip_reg    <= host_ip_next;
            alloc_reg      <= alloc_next;
            offered_reg    <= offered_next;
        end
    end

endmodule

// File: dv/tb_dhcp_reply_option_parser_top.sv
// Self-checking testbench for dhcp_reply_option_parser_top: drives reply packets byte by byte
// and compares every result beat with a cycle-free model of the parser kept in this file.
// Depends on drp_pkg and the RTL of the block; needs no files or arguments.
`timescale 1ns / 100ps

module tb_dhcp_reply_option_parser_top;
    import drp_pkg::*;

    localparam int AREA_BYTES    = 312;
    localparam int AREA_END      = HDR_BYTES + AREA_BYTES;
    localparam int OPTIONS_START = HDR_BYTES + 4;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_LIMIT   = 100;

    localparam logic [7:0] OP_REQUEST  = 8'd1;
    localparam logic [7:0] MSG_REQUEST = 8'd3;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;     // [7:0] pkt_byte
    logic         s_tlast = 1'b0;   // last_byte
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [2:0] verdict, [10:3] dhcp_type, [42:11] offered_address,
    // [74:43] server_address, [75] server_id_seen, [76] address_allocated,
    // [77] address_offered, [109:78] host_address, [111:110] zero
    logic [111:0] m_tdata;

    // Model state: per packet.
    logic [31:0] xid_setting = '0;
    int unsigned rx_pos = 0;
    logic        rx_is_reply = 1'b0;
    logic [31:0] rx_xid = '0;
    logic [31:0] rx_yiaddr = '0;
    logic [31:0] rx_cookie = '0;
    phase_t      walk_phase = PH_TYPE;
    int unsigned walk_skip = 0;
    int          type_step = 0;
    logic [7:0]  type_val = '0;
    logic        type_got = 1'b0;
    int          sid_step = 0;
    logic [31:0] sid_val = '0;
    logic        sid_got = 1'b0;

    // Model state: client lease, kept across packets.
    logic [31:0] lease_server = '0;
    logic [31:0] lease_host = '0;
    logic        lease_allocated = 1'b0;
    logic        lease_offered = 1'b0;

    result_t     reply_results_due[$];
    logic [7:0]  pkt_bytes[$];

    int error_count = 0;
    int beats_checked = 0;
    int packets_sent = 0;
    int bytes_sent = 0;
    int xid_writes = 0;
    int verdict_tally[8];
    int idle_cycles = 0;
    int ready_left = 0;
    bit sender_steady = 1'b0;

    dhcp_reply_option_parser_top #(
        .OPTION_AREA_BYTES(AREA_BYTES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 clk = ~clk;

    // Mismatch reporting.
    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t ns: %s mismatch: got 0x%08h, expected 0x%08h",
                     $time, field, got, want);
    endtask

    // One option-area byte: captures in flight first, then the TLV walk.
    task automatic walk_option_byte(input logic [7:0] b);
        if (type_step == 1)
            type_step = 2;
        else if (type_step == 2)
        begin
            type_val  = b;
            type_got  = 1'b1;
            type_step = 0;
        end
        if (sid_step == 1)
            sid_step = 2;
        else if (sid_step >= 2)
        begin
            sid_val = {sid_val[23:0], b};
            sid_step++;
            if (sid_step >= 6)
            begin
                sid_got  = 1'b1;
                sid_step = 0;
            end
        end
        case (walk_phase)
            PH_TYPE:
            begin
                if (b == OPT_END)
                    walk_phase = PH_DONE;
                else if (b != OPT_PAD)
                begin
                    if (b == OPT_MSG_TYPE && !type_got && type_step == 0)
                        type_step = 1;
                    if (b == OPT_SERVER_ID && !sid_got && sid_step == 0)
                        sid_step = 1;
                    walk_phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (b == 8'd0)
                    walk_phase = PH_TYPE;
                else
                begin
                    walk_skip  = 32'(b);
                    walk_phase = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (walk_skip > 0)
                    walk_skip--;
                if (walk_skip == 0)
                    walk_phase = PH_TYPE;
            end
            default: ;
        endcase
    endtask

    // Advances the parser model by one accepted byte; a last byte queues its verdict.
    task automatic parse_reply_byte(input logic [7:0] b, input logic last);
        result_t     res;
        logic        cookie_ok;
        logic        xid_ok;
        logic        have_type;
        logic        have_sid;
        logic [7:0]  mt;
        int unsigned at;
        at = rx_pos;
        if (at < OFFSET_MAX)
        begin
            if (at == 0)
                rx_is_reply = (b == OP_REPLY);
            else if (at >= 4 && at <= 7)
                rx_xid[8 * (7 - at) +: 8] = b;
            else if (at >= 16 && at <= 19)
                rx_yiaddr[8 * (19 - at) +: 8] = b;
            else if (at >= HDR_BYTES && at < OPTIONS_START)
                rx_cookie[8 * (OPTIONS_START - 1 - at) +: 8] = b;
            else if (at >= OPTIONS_START && at < AREA_END)
                walk_option_byte(b);
            rx_pos = at + 1;
        end
        if (last)
        begin
            cookie_ok = (rx_pos >= OPTIONS_START) && (rx_cookie == MAGIC_COOKIE);
            xid_ok    = (rx_pos >= 8) && (rx_xid == xid_setting);
            have_type = cookie_ok && type_got;
            have_sid  = cookie_ok && sid_got;
            mt        = have_type ? type_val : 8'h00;
            if (!rx_is_reply)
                res.verdict = VD_NOT_REPLY;
            else if (!xid_ok)
                res.verdict = VD_WRONG_XID;
            else if (!have_type)
                res.verdict = VD_NO_TYPE;
            else if (mt == MSG_OFFER)
            begin
                res.verdict   = VD_OFFER;
                lease_offered = 1'b1;
                if (have_sid)
                    lease_server = sid_val;
            end
            else if (mt == MSG_ACK)
            begin
                if (lease_allocated)
                    res.verdict = VD_ACK_IGNORED;
                else
                begin
                    res.verdict     = VD_ACK_TAKEN;
                    lease_host      = rx_yiaddr;
                    lease_allocated = 1'b1;
                end
            end
            else if (mt == MSG_NAK)
            begin
                res.verdict     = VD_NAK;
                lease_allocated = 1'b0;
                lease_offered   = 1'b0;
            end
            else
                res.verdict = VD_OTHER_TYPE;
            res.dhcp_type         = mt;
            res.offered_address   = rx_yiaddr;
            res.server_address    = lease_server;
            res.server_id_seen    = have_sid;
            res.address_allocated = lease_allocated;
            res.address_offered   = lease_offered;
            res.host_address      = lease_host;
            reply_results_due.push_back(res);
            verdict_tally[res.verdict]++;

            rx_pos      = 0;
            rx_is_reply = 1'b0;
            rx_xid      = '0;
            rx_yiaddr   = '0;
            rx_cookie   = '0;
            walk_phase  = PH_TYPE;
            walk_skip   = 0;
            type_step   = 0;
            type_val    = '0;
            type_got    = 1'b0;
            sid_step    = 0;
            sid_val     = '0;
            sid_got     = 1'b0;
        end
    endtask

    // Compares one result beat with the oldest pending verdict.
    task automatic check_result_beat();
        result_t seen;
        result_t want;
        seen = result_t'(m_tdata[109:0]);
        beats_checked++;
        if (m_tdata[111:110] !== 2'b00)
            report_mismatch("fill bits", 32'(m_tdata[111:110]), '0);
        if (reply_results_due.size() == 0)
            report_mismatch("beat with no reply pending", m_tdata[31:0], '0);
        else
        begin
            want = reply_results_due.pop_front();
            if (seen.verdict !== want.verdict)
                report_mismatch("verdict", 32'(seen.verdict), 32'(want.verdict));
            if (seen.dhcp_type !== want.dhcp_type)
                report_mismatch("dhcp_type", 32'(seen.dhcp_type), 32'(want.dhcp_type));
            if (seen.offered_address !== want.offered_address)
                report_mismatch("offered_address", seen.offered_address,
                                want.offered_address);
            if (seen.server_address !== want.server_address)
                report_mismatch("server_address", seen.server_address,
                                want.server_address);
            if (seen.server_id_seen !== want.server_id_seen)
                report_mismatch("server_id_seen", 32'(seen.server_id_seen),
                                32'(want.server_id_seen));
            if (seen.address_allocated !== want.address_allocated)
                report_mismatch("address_allocated", 32'(seen.address_allocated),
                                32'(want.address_allocated));
            if (seen.address_offered !== want.address_offered)
                report_mismatch("address_offered", 32'(seen.address_offered),
                                32'(want.address_offered));
            if (seen.host_address !== want.host_address)
                report_mismatch("host_address", seen.host_address, want.host_address);
        end
    endtask

    // Monitor: checks result beats and feeds accepted bytes to the model.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_result_beat();
            if (s_tvalid && s_tready)
                parse_reply_byte(s_tdata, s_tlast);
        end
    end

    // Result side back-pressure: long open stretches, short stalls and a few long ones.
    always @(posedge clk)
    begin
        if (ready_left > 0)
            ready_left <= ready_left - 1;
        else
        begin
            case ($urandom_range(0, 19))
                0, 1, 2:
                begin
                    m_tready   <= 1'b1;
                    ready_left <= $urandom_range(40, 200);
                end
                3:
                begin
                    m_tready   <= 1'b0;
                    ready_left <= $urandom_range(8, 40);
                end
                4, 5, 6, 7, 8, 9, 10, 11:
                begin
                    m_tready   <= 1'b0;
                    ready_left <= $urandom_range(0, 2);
                end
                default:
                begin
                    m_tready   <= 1'b1;
                    ready_left <= $urandom_range(0, 4);
                end
            endcase
        end
    end

    // Watchdog on cycles with no beat accepted anywhere.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sends one byte and waits for its handshake; valid stays high for a following byte.
    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        gap = sender_steady ? 0 : next_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_packet();
        sender_steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < pkt_bytes.size(); i++)
            send_beat(pkt_bytes[i], i == pkt_bytes.size() - 1);
        packets_sent++;
        pkt_bytes.delete();
    endtask

    // Holds the sender and waits until every pending verdict has come back.
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (reply_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_transaction_id(input logic [31:0] value);
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        xid_setting = value;
        xid_writes++;
    endtask

    // Packet builders working on pkt_bytes.
    task automatic put_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            pkt_bytes.push_back(w[8 * i +: 8]);
    endtask

    task automatic fill_random_to(input int n);
        while (pkt_bytes.size() < n)
            pkt_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic pad_to(input int n);
        while (pkt_bytes.size() < n)
            pkt_bytes.push_back(OPT_PAD);
    endtask

    task automatic truncate_to(input int n);
        while (pkt_bytes.size() > n)
            void'(pkt_bytes.pop_back());
    endtask

    task automatic start_reply(input logic [7:0] op, input logic [31:0] xid,
                               input logic [31:0] yiaddr);
        pkt_bytes.delete();
        pkt_bytes.push_back(op);
        fill_random_to(4);
        put_word(xid);
        fill_random_to(16);
        put_word(yiaddr);
        fill_random_to(HDR_BYTES);
    endtask

    // Option code and length, then the value: lead bytes first, random after them.
    task automatic put_option(input logic [7:0] code, input logic [7:0] len,
                              input logic [31:0] lead);
        pkt_bytes.push_back(code);
        pkt_bytes.push_back(len);
        for (int i = 0; i < len; i++)
        begin
            if (i < 4)
                pkt_bytes.push_back(lead[8 * (3 - i) +: 8]);
            else
                pkt_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_typed_reply(input logic [7:0] op, input logic [31:0] xid,
                                    input logic [7:0] mtype, input logic [31:0] yiaddr);
        start_reply(op, xid, yiaddr);
        put_word(MAGIC_COOKIE);
        put_option(OPT_MSG_TYPE, 8'd1, {mtype, 24'h0});
        put_option(OPT_SERVER_ID, 8'd4, $urandom);
        pkt_bytes.push_back(OPT_END);
        send_packet();
    endtask

    // Transaction id still at its reset value.
    task automatic test_reset_xid();
        send_typed_reply(OP_REPLY, 32'h0, MSG_OFFER, 32'h0);
    endtask

    // Every verdict in a sequence that walks the client flags.
    task automatic test_verdicts();
        set_transaction_id(32'hFFFF_FFFF);
        send_typed_reply(OP_REQUEST, xid_setting, MSG_OFFER, $urandom);
        send_typed_reply(OP_REPLY, xid_setting ^ 32'h8000_0001, MSG_OFFER, $urandom);
        // Reply with a server id but no message type.
        start_reply(OP_REPLY, xid_setting, $urandom);
        put_word(MAGIC_COOKIE);
        put_option(OPT_SERVER_ID, 8'd4, $urandom);
        pkt_bytes.push_back(OPT_END);
        send_packet();
        send_typed_reply(OP_REPLY, xid_setting, MSG_REQUEST, $urandom);
        send_typed_reply(OP_REPLY, xid_setting, MSG_OFFER, 32'hFFFF_FFFF);
        send_typed_reply(OP_REPLY, xid_setting, MSG_ACK, $urandom);
        send_typed_reply(OP_REPLY, xid_setting, MSG_ACK, $urandom);
        send_typed_reply(OP_REPLY, xid_setting, MSG_NAK, $urandom);
        send_typed_reply(OP_REPLY, xid_setting, MSG_ACK, $urandom);
    endtask

    // Corner cases of the option walk and of the captures.
    task automatic test_option_walk();
        // Pads, then a type option of length zero: the value is still the next byte.
        start_reply(OP_REPLY, xid_setting, $urandom);
        put_word(MAGIC_COOKIE);
        repeat (3) pkt_bytes.push_back(OPT_PAD);
        pkt_bytes.push_back(OPT_MSG_TYPE);
        pkt_bytes.push_back(8'd0);
        pkt_bytes.push_back(MSG_NAK);
        pkt_bytes.push_back(OPT_END);
        send_packet();
        // Type option longer than one byte.
        start_reply(OP_REPLY, xid_setting, $urandom);
        put_word(MAGIC_COOKIE);
        put_option(OPT_MSG_TYPE, 8'd3, {MSG_ACK, 24'h0});
        pkt_bytes.push_back(OPT_END);
        send_packet();
        // Options after the end option are not seen.
        start_reply(OP_REPLY, xid_setting, $urandom);
        put_word(MAGIC_COOKIE);
        pkt_bytes.push_back(OPT_END);
        put_option(OPT_MSG_TYPE, 8'd1, {MSG_OFFER, 24'h0});
        send_packet();
        // A server id capture begun before the end option still completes.
        start_reply(OP_REPLY, xid_setting, $urandom);
        put_word(MAGIC_COOKIE);
        put_option(OPT_MSG_TYPE, 8'd1, {MSG_OFFER, 24'h0});
        pkt_bytes.push_back(OPT_SERVER_ID);
        pkt_bytes.push_back(8'd0);
        pkt_bytes.push_back(OPT_END);
        put_word($urandom);
        send_packet();
        // Bad cookie hides well-formed options.
        start_reply(OP_REPLY, xid_setting, $urandom);
        put_word(MAGIC_COOKIE ^ 32'h0000_0100);
        put_option(OPT_MSG_TYPE, 8'd1, {MSG_OFFER, 24'h0});
        put_option(OPT_SERVER_ID, 8'd4, $urandom);
        pkt_bytes.push_back(OPT_END);
        send_packet();
        // Short server option reads past its length; later duplicates are ignored.
        start_reply(OP_REPLY, xid_setting, $urandom);
        put_word(MAGIC_COOKIE);
        put_option(OPT_SERVER_ID, 8'd2, $urandom);
        put_option(OPT_MSG_TYPE, 8'd1, {MSG_ACK, 24'h0});
        put_option(OPT_MSG_TYPE, 8'd1, {MSG_OFFER, 24'h0});
        put_option(OPT_SERVER_ID, 8'd4, $urandom);
        pkt_bytes.push_back(OPT_END);
        send_packet();
        // Packet ends before the type value.
        start_reply(OP_REPLY, xid_setting, $urandom);
        put_word(MAGIC_COOKIE);
        pkt_bytes.push_back(OPT_MSG_TYPE);
        pkt_bytes.push_back(8'd1);
        send_packet();
    endtask

    // Short packets, captures at the area edge and packets past the offset limit.
    task automatic test_packet_length();
        pkt_bytes.push_back(OP_REPLY);
        send_packet();
        start_reply(OP_REPLY, xid_setting, $urandom);
        truncate_to(6);
        send_packet();
        start_reply(OP_REPLY, xid_setting, $urandom);
        put_word(MAGIC_COOKIE);
        truncate_to(HDR_BYTES + 2);
        send_packet();
        // Server id whose last byte falls outside the area.
        start_reply(OP_REPLY, xid_setting, $urandom);
        put_word(MAGIC_COOKIE);
        put_option(OPT_MSG_TYPE, 8'd1, {MSG_OFFER, 24'h0});
        pad_to(AREA_END - 5);
        put_option(OPT_SERVER_ID, 8'd4, $urandom);
        fill_random_to(AREA_END + 12);
        send_packet();
        // Type value one byte past the area.
        start_reply(OP_REPLY, xid_setting, $urandom);
        put_word(MAGIC_COOKIE);
        pad_to(AREA_END - 2);
        put_option(OPT_MSG_TYPE, 8'd1, {MSG_OFFER, 24'h0});
        fill_random_to(AREA_END + 4);
        send_packet();
        // Type value in the last area byte, then a tail past the offset limit.
        start_reply(OP_REPLY, xid_setting, $urandom);
        put_word(MAGIC_COOKIE);
        pad_to(AREA_END - 3);
        put_option(OPT_MSG_TYPE, 8'd1, {MSG_NAK, 24'h0});
        fill_random_to(1100);
        send_packet();
    endtask

    function automatic logic [7:0] pick_msg_type();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return MSG_OFFER;
        if (r < 65)
            return MSG_ACK;
        if (r < 80)
            return MSG_NAK;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic put_random_option();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            pkt_bytes.push_back(OPT_PAD);
        else if (r < 55)
            put_option(OPT_SERVER_ID,
                       ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 6)) : 8'd4,
                       $urandom);
        else
            put_option(8'($urandom_range(1, 254)), 8'($urandom_range(0, 12)), $urandom);
    endtask

    // Mostly well-formed replies with random content, some noise, cut and long packets.
    task automatic build_random_reply();
        int          r;
        logic [7:0]  op;
        logic [31:0] xid;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            pkt_bytes.delete();
            fill_random_to($urandom_range(1, 300));
        end
        else
        begin
            op  = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : OP_REPLY;
            xid = ($urandom_range(0, 9) == 0) ? $urandom : xid_setting;
            start_reply(op, xid, $urandom);
            case ($urandom_range(0, 19))
                0: put_word($urandom);
                1: put_word(MAGIC_COOKIE ^ (32'd1 << $urandom_range(0, 31)));
                default: put_word(MAGIC_COOKIE);
            endcase
            repeat ($urandom_range(0, 2)) put_random_option();
            if ($urandom_range(0, 99) < 85)
                put_option(OPT_MSG_TYPE,
                           ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 3)) : 8'd1,
                           {pick_msg_type(), 24'h0});
            repeat ($urandom_range(0, 3)) put_random_option();
            if ($urandom_range(0, 9) < 7)
                pkt_bytes.push_back(OPT_END);
            repeat ($urandom_range(0, 20)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
            if (r < 14)
                truncate_to($urandom_range(1, pkt_bytes.size()));
            else if (r < 17)
                fill_random_to($urandom_range(560, 1100));
        end
    endtask

    // Random traffic under several transaction ids, the extremes among them.
    task automatic test_random_traffic();
        int          phase_packets;
        logic [31:0] id;
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: id = 32'h0;
                3: id = 32'hFFFF_FFFF;
                default: id = $urandom;
            endcase
            set_transaction_id(id);
            phase_packets = 0;
            while (phase_packets < 3)
            begin
                build_random_reply();
                send_packet();
                phase_packets++;
                if ($urandom_range(0, 19) == 0)
                    wait_results_done();
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_xid();
        test_verdicts();
        test_option_walk();
        test_packet_length();
        test_random_traffic();

        wait_results_done();
        repeat (10) @(posedge clk);

        $display("Sent %0d packets (%0d bytes) under %0d transaction ids, %0d beats checked.",
                 packets_sent, bytes_sent, xid_writes, beats_checked);
        $write("Verdicts: not reply %0d, wrong xid %0d, no type %0d, other %0d, ",
               verdict_tally[VD_NOT_REPLY], verdict_tally[VD_WRONG_XID],
               verdict_tally[VD_NO_TYPE], verdict_tally[VD_OTHER_TYPE]);
        $display("offer %0d, ack taken %0d, ack ignored %0d, nak %0d",
                 verdict_tally[VD_OFFER], verdict_tally[VD_ACK_TAKEN],
                 verdict_tally[VD_ACK_IGNORED], verdict_tally[VD_NAK]);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: dhcp_reply_option_parser_top.f
sv/drp_pkg.sv
sv/drp_parse.sv
sv/dhcp_reply_option_parser_top.sv
dv/tb_dhcp_reply_option_parser_top.sv
